@@ hdl/fftk_pkg.sv @@
// ----------------------------------------------------------------------------
// fftk_pkg
// Shared types and constants of the follow feed top-k merge block.
// ----------------------------------------------------------------------------
package fftk_pkg;

	// field widths fixed by the interface
	localparam int TYPE_W = 2;
	localparam int UID_W  = 6;
	localparam int ID_W   = 31;

	// parameter defaults
	localparam int USERS_DEF     = 64;
	localparam int FEED_LEN_DEF  = 10;
	localparam int TIME_BITS_DEF = 32;

	// request codes
	localparam logic [TYPE_W-1:0] REQ_POST     = 2'd0;
	localparam logic [TYPE_W-1:0] REQ_FEED     = 2'd1;
	localparam logic [TYPE_W-1:0] REQ_FOLLOW   = 2'd2;
	localparam logic [TYPE_W-1:0] REQ_UNFOLLOW = 2'd3;

	// control of the top-k list
	typedef struct packed {
		logic clear;
		logic insert;
	} sort_ctrl_t;

endpackage

@@ hdl/follow_feed_top_k_merge_core.sv @@
// ----------------------------------------------------------------------------
// follow_feed_top_k_merge_core
// Post, follow and feed requests over per-user post rings and a follow matrix.
// ----------------------------------------------------------------------------
// Post, follow and unfollow pass through a read and a write state; out-of-range ones stay idle.
// A feed reads the follow row and scans every ring slot once through the post RAM
//   read port, then gives one word per cycle (1..FEED_LEN words).
// One request at a time; results are strobed and cannot be stalled.
// After reset a clearing pass over every user zeroes the count and follow
// RAMs, with busy high.
module follow_feed_top_k_merge_core import fftk_pkg::*; #(
	parameter int USERS     = USERS_DEF,
	parameter int FEED_LEN  = FEED_LEN_DEF,
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [TYPE_W-1:0] req_type,
	input  logic [UID_W-1:0]  user_id,
	input  logic [UID_W-1:0]  other_user,
	input  logic [ID_W-1:0]   tweet_id,
	output logic              feed_valid,
	output logic [ID_W-1:0]   feed_tweet,
	output logic              has_tweet,
	output logic              last_item
);

	localparam int UW  = $clog2(USERS);
	localparam int SW  = (FEED_LEN > 1) ? $clog2(FEED_LEN) : 1;
	localparam int CW  = $clog2(FEED_LEN + 1);
	localparam int PD  = USERS * FEED_LEN;
	localparam int PAW = $clog2(PD);
	localparam int KW  = TIME_BITS + ID_W;
	localparam int MW  = CW + SW;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_POST_RD, ST_POST_WR, ST_FOL_RD, ST_FOL_WR,
		ST_FEED_ROW, ST_FEED_LAT, ST_SCAN, ST_DRAIN, ST_OUT
	} state_t;

	state_t              state_q;
	logic [TYPE_W-1:0]   type_q;
	logic [UW-1:0]       user_q;
	logic [UW-1:0]       oth_q;
	logic [ID_W-1:0]     tid_q;
	logic [TIME_BITS-1:0] clock_q;
	logic [UW-1:0]       clr_q;
	logic [USERS-1:0]    row_q;
	logic [UW-1:0]       u_q;
	logic [SW-1:0]       s_q;
	logic [PAW-1:0]      addr_q;
	logic [SW-1:0]       idx_q;
	logic                v_s1;
	logic [UW-1:0]       u_s1;
	logic [SW-1:0]       s_s1;
	logic                feed_valid_q;
	logic [ID_W-1:0]     feed_tweet_q;
	logic                has_tweet_q;
	logic                last_item_q;

	logic                accept;
	logic                user_ok;
	logic                oth_ok;

	// memories
	logic                post_we;
	logic [PAW-1:0]      post_waddr;
	logic [KW-1:0]       post_wdata;
	logic [KW-1:0]       post_rdata;
	logic                meta_we;
	logic [UW-1:0]       meta_waddr;
	logic [MW-1:0]       meta_wdata;
	logic [UW-1:0]       meta_raddr;
	logic [MW-1:0]       meta_rdata;
	logic                fol_we;
	logic [UW-1:0]       fol_waddr;
	logic [USERS-1:0]    fol_wdata;
	logic [USERS-1:0]    fol_rdata;
	logic [USERS-1:0]    fol_mask;

	logic [CW-1:0]       cnt_rd;
	logic [SW-1:0]       slot_rd;
	logic [CW-1:0]       cnt_nx;
	logic [SW-1:0]       slot_nx;

	sort_ctrl_t          sctrl;
	logic [KW-1:0]       list [FEED_LEN];
	logic [FEED_LEN-1:0] vld;
	logic [SW-1:0]       idx_nx;
	logic                idx_last;
	logic                out_last;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	assign user_ok = (32'(user_id) < USERS);
	assign oth_ok  = (32'(other_user) < USERS);

	// count and ring slot of the addressed user
	assign cnt_rd  = meta_rdata[MW-1:SW];
	assign slot_rd = meta_rdata[SW-1:0];
	assign slot_nx = (slot_rd == SW'(FEED_LEN - 1)) ? '0 : slot_rd + 1'b1;
	assign cnt_nx  = (cnt_rd == CW'(FEED_LEN)) ? cnt_rd : cnt_rd + 1'b1;

	// post ring write
	assign post_we    = (state_q == ST_POST_WR);
	assign post_waddr = PAW'(user_q) * PAW'(FEED_LEN) + PAW'(slot_rd);
	assign post_wdata = {clock_q, tid_q};

	assign meta_we    = (state_q == ST_CLEAR) || (state_q == ST_POST_WR);
	assign meta_waddr = (state_q == ST_CLEAR) ? clr_q : user_q;
	assign meta_wdata = (state_q == ST_CLEAR) ? '0 : {cnt_nx, slot_nx};
	assign meta_raddr = (state_q == ST_SCAN) ? u_q : user_q;

	// follow row update
	assign fol_mask  = {{(USERS-1){1'b0}}, 1'b1} << oth_q;
	assign fol_we    = (state_q == ST_CLEAR) || (state_q == ST_FOL_WR);
	assign fol_waddr = (state_q == ST_CLEAR) ? clr_q : user_q;
	always_comb begin
		if (state_q == ST_CLEAR) begin
			fol_wdata = '0;
		end else if (type_q == REQ_FOLLOW) begin
			fol_wdata = fol_rdata | fol_mask;
		end else begin
			fol_wdata = fol_rdata & ~fol_mask;
		end
	end

	fftk_ram #(.W(KW), .D(PD)) u_post_ram (
		.clk   (clk),
		.we    (post_we),
		.waddr (post_waddr),
		.wdata (post_wdata),
		.raddr (addr_q),
		.rdata (post_rdata)
	);

	fftk_ram #(.W(MW), .D(USERS)) u_meta_ram (
		.clk   (clk),
		.we    (meta_we),
		.waddr (meta_waddr),
		.wdata (meta_wdata),
		.raddr (meta_raddr),
		.rdata (meta_rdata)
	);

	fftk_ram #(.W(USERS), .D(USERS)) u_fol_ram (
		.clk   (clk),
		.we    (fol_we),
		.waddr (fol_waddr),
		.wdata (fol_wdata),
		.raddr (user_q),
		.rdata (fol_rdata)
	);

	// candidate from the scan: own posts or a followee, slot below count
	assign sctrl.clear  = accept && (req_type == REQ_FEED);
	assign sctrl.insert = v_s1 && ((u_s1 == user_q) || row_q[u_s1])
		&& (CW'(s_s1) < cnt_rd);

	fftk_sort #(.FEED_LEN(FEED_LEN), .KW(KW)) u_sort (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (sctrl),
		.key    (post_rdata),
		.list   (list),
		.vld    (vld)
	);

	// result word selection
	assign idx_last = (idx_q == SW'(FEED_LEN - 1));
	assign idx_nx   = idx_q + 1'b1;
	assign out_last = !vld[idx_q] || idx_last || !vld[idx_nx];

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			type_q       <= REQ_POST;
			user_q       <= '0;
			oth_q        <= '0;
			tid_q        <= '0;
			clock_q      <= '0;
			clr_q        <= '0;
			row_q        <= '0;
			u_q          <= '0;
			s_q          <= '0;
			addr_q       <= '0;
			idx_q        <= '0;
			v_s1         <= 1'b0;
			u_s1         <= '0;
			s_s1         <= '0;
			feed_valid_q <= 1'b0;
			feed_tweet_q <= '0;
			has_tweet_q  <= 1'b0;
			last_item_q  <= 1'b0;
		end else begin
			feed_valid_q <= 1'b0;
			v_s1         <= (state_q == ST_SCAN);
			u_s1         <= u_q;
			s_s1         <= s_q;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == UW'(USERS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						type_q <= req_type;
						user_q <= UW'(user_id);
						oth_q  <= UW'(other_user);
						tid_q  <= tweet_id;
						unique case (req_type)
							REQ_POST: begin
								if (user_ok) state_q <= ST_POST_RD;
							end
							REQ_FEED: begin
								idx_q   <= '0;
								u_q     <= '0;
								s_q     <= '0;
								addr_q  <= '0;
								state_q <= user_ok ? ST_FEED_ROW : ST_OUT;
							end
							REQ_FOLLOW, REQ_UNFOLLOW: begin
								if (user_ok && oth_ok && (user_id != other_user)) begin
									state_q <= ST_FOL_RD;
								end
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_POST_RD: state_q <= ST_POST_WR;
				ST_POST_WR: begin
					if (clock_q != {TIME_BITS{1'b1}}) begin
						clock_q <= clock_q + 1'b1;
					end
					state_q <= ST_IDLE;
				end
				ST_FOL_RD: state_q <= ST_FOL_WR;
				ST_FOL_WR: state_q <= ST_IDLE;
				ST_FEED_ROW: state_q <= ST_FEED_LAT;
				ST_FEED_LAT: begin
					row_q   <= fol_rdata;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					addr_q <= addr_q + 1'b1;
					if (s_q == SW'(FEED_LEN - 1)) begin
						s_q <= '0;
						u_q <= u_q + 1'b1;
						if (u_q == UW'(USERS - 1)) begin
							state_q <= ST_DRAIN;
						end
					end else begin
						s_q <= s_q + 1'b1;
					end
				end
				ST_DRAIN: state_q <= ST_OUT;
				ST_OUT: begin
					feed_valid_q <= 1'b1;
					has_tweet_q  <= vld[idx_q];
					feed_tweet_q <= vld[idx_q] ? list[idx_q][ID_W-1:0] : '0;
					last_item_q  <= out_last;
					idx_q        <= idx_nx;
					if (out_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign feed_valid = feed_valid_q;
	assign feed_tweet = feed_tweet_q;
	assign has_tweet  = has_tweet_q;
	assign last_item  = last_item_q;

	// a feed continues until its last word
	a_feed_cont: assert property (@(posedge clk) disable iff (!arst_n)
		feed_valid && !last_item |=> feed_valid)
		else $error("feed words not contiguous");

	// an empty feed is a single word
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		feed_valid && !has_tweet |-> last_item)
		else $error("empty word not last");

	// no new request while a feed is still being delivered
	a_busy_feed: assert property (@(posedge clk) disable iff (!arst_n)
		feed_valid && !last_item |-> busy)
		else $error("idle during feed delivery");

endmodule

@@ hdl/fftk_ram.sv @@
// ----------------------------------------------------------------------------
// fftk_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module fftk_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem [D];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hdl/fftk_sort.sv @@
// ----------------------------------------------------------------------------
// fftk_sort
// Sorted list of the best keys seen so far, one insertion per cycle.
// ----------------------------------------------------------------------------
module fftk_sort import fftk_pkg::*; #(
	parameter int FEED_LEN = FEED_LEN_DEF,
	parameter int KW       = TIME_BITS_DEF + ID_W
) (
	input  logic                clk,
	input  logic                arst_n,
	input  sort_ctrl_t          ctrl,
	input  logic [KW-1:0]       key,
	output logic [KW-1:0]       list [FEED_LEN],
	output logic [FEED_LEN-1:0] vld
);

	logic [KW-1:0]       list_q [FEED_LEN];
	logic [FEED_LEN-1:0] vld_q;
	logic [FEED_LEN-1:0] gt;
	logic [FEED_LEN-1:0] take_key;
	logic [FEED_LEN-1:0] vld_nx;

	// slot i moves when it is empty or the new key ranks strictly above it
	for (genvar i = 0; i < FEED_LEN; i++) begin : g_cmp
		assign gt[i] = !vld_q[i] || (key > list_q[i]);
		if (i == 0) begin : g_head
			assign take_key[i] = 1'b1;
			assign vld_nx[i]   = 1'b1;
			always_ff @(posedge clk) begin
				if (ctrl.insert && gt[i]) begin
					list_q[i] <= key;
				end
			end
		end else begin : g_tail
			assign take_key[i] = !gt[i-1];
			assign vld_nx[i]   = take_key[i] ? 1'b1 : vld_q[i-1];
			always_ff @(posedge clk) begin
				if (ctrl.insert && gt[i]) begin
					list_q[i] <= take_key[i] ? key : list_q[i-1];
				end
			end
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (ctrl.clear) begin
			vld_q <= '0;
		end else if (ctrl.insert) begin
			for (int i = 0; i < FEED_LEN; i++) begin
				if (gt[i]) begin
					vld_q[i] <= vld_nx[i];
				end
			end
		end
	end

	assign list = list_q;
	assign vld  = vld_q;

endmodule

@@ verif/fftk_feed_checker.sv @@
// ----------------------------------------------------------------------------
// fftk_feed_checker
// Watches accepted requests, keeps its own copy of posts and follows, works
// out each expected feed and compares every strobed result word against it.
// ----------------------------------------------------------------------------
module fftk_feed_checker import fftk_pkg::*; #(
	parameter int USERS     = USERS_DEF,
	parameter int FEED_LEN  = FEED_LEN_DEF,
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  logic [TYPE_W-1:0] req_type,
	input  logic [UID_W-1:0]  user_id,
	input  logic [UID_W-1:0]  other_user,
	input  logic [ID_W-1:0]   tweet_id,
	input  logic              feed_valid,
	input  logic [ID_W-1:0]   feed_tweet,
	input  logic              has_tweet,
	input  logic              last_item,
	output int                fail_count,
	output int                words_pending
);

	typedef struct packed {
		logic [ID_W-1:0] tweet;
		logic            valid;
		logic            last;
	} feed_word_t;

	logic [TIME_BITS-1:0] stamp_of [USERS][FEED_LEN];
	logic [ID_W-1:0]      id_of    [USERS][FEED_LEN];
	int                   count_of [USERS];
	int                   slot_of  [USERS];
	logic [USERS-1:0]     follows_of [USERS];
	logic [TIME_BITS-1:0] post_clock;
	feed_word_t           feed_q [$];

	task automatic report_mismatch(input string what);
		$display("mismatch: %s", what);
		fail_count++;
	endtask

	// append one expected word at the tail
	task automatic add_expected(input feed_word_t w);
		feed_q = {feed_q, w};
	endtask

	// true if (sa,ia,ua,la) ranks strictly above (sb,ib,ub,lb)
	function automatic bit outranks(input logic [TIME_BITS-1:0] sa, input logic [ID_W-1:0] ia,
			input int ua, input int la, input logic [TIME_BITS-1:0] sb,
			input logic [ID_W-1:0] ib, input int ub, input int lb);
		if (sa != sb) return sa > sb;
		if (ia != ib) return ia > ib;
		if (ua != ub) return ua > ub;
		return la > lb;
	endfunction

	// merge own and followed rings, newest first
	task automatic predict_feed(input int who);
		logic [TIME_BITS-1:0] ps, bs;
		logic [ID_W-1:0]      pi, bi;
		int                   pu, pl, bu, bl, n;
		bit                   have_prev, found;
		n = 0;
		have_prev = 0;
		ps = '0; pi = '0; pu = 0; pl = 0;
		if (who < USERS) begin
			for (int k = 0; k < FEED_LEN; k++) begin
				found = 0;
				bs = '0; bi = '0; bu = 0; bl = 0;
				for (int u = 0; u < USERS; u++) begin
					if (u != who && !follows_of[who][u]) continue;
					for (int s = 0; s < count_of[u]; s++) begin
						if (have_prev && !outranks(ps, pi, pu, pl, stamp_of[u][s],
								id_of[u][s], u, s))
							continue;
						if (!found || outranks(stamp_of[u][s], id_of[u][s], u, s,
								bs, bi, bu, bl)) begin
							bs = stamp_of[u][s]; bi = id_of[u][s]; bu = u; bl = s;
							found = 1;
						end
					end
				end
				if (!found) break;
				add_expected(feed_word_t'{tweet: bi, valid: 1'b1, last: 1'b0});
				n++;
				ps = bs; pi = bi; pu = bu; pl = bl;
				have_prev = 1;
			end
		end
		if (n == 0) add_expected(feed_word_t'{tweet: '0, valid: 1'b0, last: 1'b1});
		else feed_q[feed_q.size()-1].last = 1'b1;
	endtask

	// check each strobed result word, then update state or predict a feed
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int u = 0; u < USERS; u++) begin
				count_of[u] = 0;
				slot_of[u] = 0;
				follows_of[u] = '0;
			end
			post_clock = '0;
			fail_count = 0;
			feed_q.delete();
			words_pending = 0;
		end else begin
			if (feed_valid) begin
				if (feed_q.size() == 0) report_mismatch("result word with none expected");
				else begin
					feed_word_t e;
					e = feed_q.pop_front();
					if (feed_tweet !== e.tweet || has_tweet !== e.valid || last_item !== e.last)
						report_mismatch($sformatf("got %0d/%b/%b exp %0d/%b/%b",
							feed_tweet, has_tweet, last_item, e.tweet, e.valid, e.last));
				end
			end
			if (start && !busy) begin
				case (req_type)
					REQ_POST: if (user_id < USERS) begin
						stamp_of[user_id][slot_of[user_id]] = post_clock;
						id_of[user_id][slot_of[user_id]] = tweet_id;
						slot_of[user_id] = (slot_of[user_id] + 1) % FEED_LEN;
						if (count_of[user_id] < FEED_LEN) count_of[user_id]++;
						if (post_clock != '1) post_clock++;
					end
					REQ_FEED: predict_feed(user_id);
					default: if (user_id < USERS && other_user < USERS
							&& user_id != other_user)
						follows_of[user_id][other_user] = (req_type == REQ_FOLLOW);
				endcase
			end
			words_pending = feed_q.size();
		end
	end

endmodule

@@ verif/tb_follow_feed_top_k_merge_core.sv @@
// ----------------------------------------------------------------------------
// tb_follow_feed_top_k_merge_core
// Directed and random post, follow, unfollow and feed requests, sent in
// bursts with random gaps; a checker beside the block predicts every feed.
// ----------------------------------------------------------------------------
module tb_follow_feed_top_k_merge_core;
	import fftk_pkg::*;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [TYPE_W-1:0] req_type;
	logic [UID_W-1:0]  user_id;
	logic [UID_W-1:0]  other_user;
	logic [ID_W-1:0]   tweet_id;
	logic              feed_valid;
	logic [ID_W-1:0]   feed_tweet;
	logic              has_tweet;
	logic              last_item;
	int                fail_count;
	int                words_pending;

	follow_feed_top_k_merge_core dut (.*);
	fftk_feed_checker chk (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// send one request word and wait for its acceptance; start stays high
	task automatic send_req(input logic [TYPE_W-1:0] t, input int u, input int o,
			input logic [ID_W-1:0] id);
		start <= 1'b1;
		req_type <= t;
		user_id <= u[UID_W-1:0];
		other_user <= o[UID_W-1:0];
		tweet_id <= id;
		do @(posedge clk); while (busy);
	endtask

	// pick a random request, mostly among a few active users
	task automatic send_random;
		int u, o, r;
		logic [ID_W-1:0] id;
		u = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 5);
		o = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 5);
		id = ($urandom_range(0, 4) == 0) ? ID_W'($urandom_range(0, 3)) : ID_W'($urandom);
		r = $urandom_range(0, 9);
		if (r < 5) send_req(REQ_POST, u, o, id);
		else if (r < 7) send_req(REQ_FOLLOW, u, o, id);
		else if (r < 8) send_req(REQ_UNFOLLOW, u, o, id);
		else send_req(REQ_FEED, u, o, id);
	endtask

	initial begin
		int burst;
		int gap;
		arst_n = 1'b0;
		start = 1'b0;
		req_type = REQ_POST;
		user_id = '0;
		other_user = '0;
		tweet_id = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: empty feed, extremes, self-follow, ring wrap, equal ids
		send_req(REQ_FEED, 0, 0, '0);
		send_req(REQ_POST, 0, 63, '1);
		send_req(REQ_POST, 63, 0, '0);
		send_req(REQ_FOLLOW, 1, 1, '0);
		send_req(REQ_FEED, 1, 0, '0);
		send_req(REQ_FOLLOW, 1, 0, '0);
		send_req(REQ_FOLLOW, 1, 63, '1);
		send_req(REQ_FEED, 1, 0, '1);
		send_req(REQ_UNFOLLOW, 1, 2, '0);
		for (int i = 0; i < 12; i++) send_req(REQ_POST, 2, 0, ID_W'(i % 3));
		send_req(REQ_FOLLOW, 1, 2, '0);
		send_req(REQ_FEED, 1, 0, '0);
		send_req(REQ_UNFOLLOW, 1, 0, '0);
		send_req(REQ_FEED, 1, 63, '0);
		// random part in bursts
		burst = 0;
		for (int n = 0; n < 125; n++) begin
			if (burst == 0) begin
				burst = $urandom_range(1, 8);
				gap = $urandom_range(0, 20);
				if (gap != 0) begin
					start <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			burst--;
			send_random();
		end
		start <= 1'b0;
		while (words_pending != 0) @(posedge clk);
		repeat (700) @(posedge clk);
		if (fail_count == 0) $display("ALL CHECKS PASSED");
		else $display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#10000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
